// File: hw/rtl/bilinear_image_scaler_defines.svh
// assertion macros for the bilinear image scaler checker
// no dependencies; included by the checker file
`ifndef BILINEAR_IMAGE_SCALER_DEFINES_SVH
`define BILINEAR_IMAGE_SCALER_DEFINES_SVH

// same-cycle implication, off during reset
`define BIS_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bilinear scaler check failed");

// next-cycle implication, off during reset
`define BIS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bilinear scaler check failed");

// next-cycle implication, always on
`define BIS_ASSERT_ALWAYS(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("bilinear scaler check failed");

`endif

// File: hw/rtl/bis_pkg.sv
// shared types and constants of the bilinear image scaler
// no dependencies
package bis_pkg;

   localparam int SZ_W      = 9;
   localparam int COORD_W   = 9;
   localparam int NUM_W     = 25;
   localparam int QUO_W     = 17;
   localparam int WGT_W     = 9;
   localparam int PROD_W    = 17;
   localparam int PIX_W     = 32;
   localparam int CH_PROD_W = 25;
   localparam int Q_DEPTH   = 4;
   localparam int OUT_DEPTH = 32;

   typedef enum logic {
      KIND_LOAD = 1'b0,
      KIND_REQ  = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      REG_SRC_W = 2'd0,
      REG_SRC_H = 2'd1,
      REG_DST_W = 2'd2,
      REG_DST_H = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [SZ_W-1:0] src_w;
      logic [SZ_W-1:0] src_h;
      logic [SZ_W-1:0] dst_w;
      logic [SZ_W-1:0] dst_h;
   } size_type;

   typedef struct packed {
      kind_type         kind;
      logic             err;
      logic [7:0]       col;
      logic [7:0]       row;
      logic [PIX_W-1:0] pixel;
      logic [NUM_W-1:0] num_x;
      logic [NUM_W-1:0] num_y;
   } item_type;

   typedef struct packed {
      logic             err;
      logic [PIX_W-1:0] pixel;
   } result_type;

   function automatic logic [SZ_W-1:0] clamp_size(input logic [SZ_W-1:0] v,
                                                  input int unsigned maxv);
      logic [SZ_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = SZ_W'(1);
      end else if (32'(v) > maxv) begin
         r = SZ_W'(maxv);
      end
      return r;
   endfunction

endpackage

// File: hw/rtl/bis_fifo.sv
// small synchronous fifo used as the item queue and the result buffer
// no dependencies
module bis_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] din,
   input  logic             pop,
   output logic [WIDTH-1:0] dout,
   output logic             full,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] data_ff [DEPTH];
   logic [PTR_W-1:0] wptr_ff, wptr_in;
   logic [PTR_W-1:0] rptr_ff, rptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   assign full  = (cnt_ff == CNT_W'(DEPTH));
   assign empty = (cnt_ff == '0);
   assign dout  = data_ff[rptr_ff];

   always_comb begin
      wptr_in = wptr_ff;
      rptr_in = rptr_ff;
      cnt_in  = cnt_ff;
      if (push) begin
         wptr_in = (wptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
      end
      if (pop) begin
         rptr_in = (rptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         data_ff[wptr_ff] <= din;
      end
   end

endmodule

// File: hw/rtl/bis_front.sv
// front end: takes input words, flags bad requests, forms divider numerators
// depends on bis_pkg
module bis_front (
   input  logic                clock,
   input  logic                reset,
   input  bis_pkg::size_type   sizes,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [47:0]         req_tdata,
   input  logic [0:0]          req_tuser,
   input  logic                q_full,
   output logic                q_push,
   output bis_pkg::item_type   q_item
);

   logic              valid_ff, valid_in;
   bis_pkg::item_type item_ff, item_in;
   logic              accept;
   logic [17:0]       prod_x, prod_y;

   assign req_tready = !valid_ff || !q_full;
   assign accept     = req_tvalid && req_tready;
   assign q_push     = valid_ff && !q_full;
   assign q_item     = item_ff;

   always_comb begin
      prod_x         = 18'({req_tdata[7:0], 1'b1}) * 18'(sizes.src_w);
      prod_y         = 18'({req_tdata[15:8], 1'b1}) * 18'(sizes.src_h);
      item_in.kind   = bis_pkg::kind_type'(req_tuser[0]);
      item_in.col    = req_tdata[7:0];
      item_in.row    = req_tdata[15:8];
      item_in.pixel  = req_tdata[47:16];
      item_in.err    = (req_tuser[0] == bis_pkg::KIND_REQ) &&
                       ((9'(req_tdata[7:0]) >= sizes.dst_w) ||
                        (9'(req_tdata[15:8]) >= sizes.dst_h));
      item_in.num_x  = {prod_x, 7'd0};
      item_in.num_y  = {prod_y, 7'd0};
      valid_in       = accept || (valid_ff && q_full);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

endmodule

// File: hw/rtl/bis_divider.sv
// pipelined restoring divider, one quotient bit per stage
// depends on bis_pkg
module bis_divider (
   input  logic                        clock,
   input  logic [bis_pkg::NUM_W-1:0]   num,
   input  logic [bis_pkg::SZ_W-1:0]    den,
   output logic [bis_pkg::QUO_W-1:0]   quo
);

   localparam int QW = bis_pkg::QUO_W;
   localparam int DW = bis_pkg::SZ_W;

   logic [DW-1:0] rem_ff [QW];
   logic [QW-1:0] lo_ff  [QW];
   logic [QW-1:0] q_ff   [QW];

   for (genvar i = 0; i < QW; i++) begin : g_stage
      logic [DW-1:0] rem_prev;
      logic [QW-1:0] lo_prev, q_prev;
      logic [DW:0]   trial;
      logic          ge;
      logic [DW-1:0] rem_in;
      logic [QW-1:0] lo_in, q_in;

      if (i == 0) begin : g_first
         assign rem_prev = DW'(num[bis_pkg::NUM_W-1:QW]);
         assign lo_prev  = num[QW-1:0];
         assign q_prev   = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[i-1];
         assign lo_prev  = lo_ff[i-1];
         assign q_prev   = q_ff[i-1];
      end

      always_comb begin
         trial  = {rem_prev, lo_prev[QW-1]};
         ge     = trial >= {1'b0, den};
         rem_in = ge ? DW'(trial - {1'b0, den}) : DW'(trial);
         lo_in  = {lo_prev[QW-2:0], 1'b0};
         q_in   = {q_prev[QW-2:0], ge};
      end

      always_ff @(posedge clock) begin
         rem_ff[i] <= rem_in;
         lo_ff[i]  <= lo_in;
         q_ff[i]   <= q_in;
      end
   end

   assign quo = q_ff[QW-1];

endmodule

// File: hw/rtl/bis_back.sv
// back end: source position divide, banked source store, weights and blend
// depends on bis_pkg and bis_divider
module bis_back #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  bis_pkg::size_type     sizes,
   input  logic                  q_empty,
   input  bis_pkg::item_type     q_item,
   output logic                  q_pop,
   input  logic                  rsp_done,
   output logic                  res_push,
   output bis_pkg::result_type   res_data
);

   localparam int HALF_W     = (MAX_WIDTH + 1) / 2;
   localparam int HALF_H     = (MAX_HEIGHT + 1) / 2;
   localparam int BANK_DEPTH = HALF_W * HALF_H;
   localparam int AW         = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
   localparam int QW         = bis_pkg::QUO_W;
   localparam int CW         = bis_pkg::COORD_W;
   localparam int WW         = bis_pkg::WGT_W;
   localparam int PW         = bis_pkg::PROD_W;
   localparam int XW         = bis_pkg::CH_PROD_W;
   localparam int CNT_W      = $clog2(bis_pkg::OUT_DEPTH + 1);

   typedef struct packed {
      logic                      valid;
      bis_pkg::kind_type         kind;
      logic                      err;
      logic [7:0]                col;
      logic [7:0]                row;
      logic [bis_pkg::PIX_W-1:0] pixel;
   } meta_type;

   typedef struct packed {
      logic                      valid;
      bis_pkg::kind_type         kind;
      logic                      err;
      logic [bis_pkg::PIX_W-1:0] pixel;
      logic                      wr_en;
      logic [1:0]                wr_bank;
      logic [AW-1:0]             wr_addr;
      logic [3:0][AW-1:0]        addr;
      logic [3:0][WW-1:0]        h;
      logic [3:0][WW-1:0]        v;
   } addr_type;

   typedef struct packed {
      logic valid;
      bis_pkg::kind_type kind;
      logic err;
   } tag_type;

   // issue with credit so the result buffer never overflows
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             take, take_req;

   assign take     = !q_empty &&
                     ((q_item.kind == bis_pkg::KIND_LOAD) ||
                      (cnt_ff < CNT_W'(bis_pkg::OUT_DEPTH)));
   assign take_req = take && (q_item.kind == bis_pkg::KIND_REQ);
   assign q_pop    = take;

   always_comb begin
      cnt_in = cnt_ff;
      if (take_req && !rsp_done) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (rsp_done && !take_req) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   // issue register
   logic                          s0_valid_ff;
   bis_pkg::item_type             s0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         cnt_ff      <= '0;
      end else begin
         s0_valid_ff <= take;
         cnt_ff      <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s0_ff <= q_item;
      end
   end

   // divide stages with matching delay line
   logic [QW-1:0] ux, uy;
   meta_type      dl_ff [QW];

   bis_divider u_div_x (
      .clock (clock),
      .num   (s0_ff.num_x),
      .den   (sizes.dst_w),
      .quo   (ux)
   );

   bis_divider u_div_y (
      .clock (clock),
      .num   (s0_ff.num_y),
      .den   (sizes.dst_h),
      .quo   (uy)
   );

   for (genvar i = 0; i < QW; i++) begin : g_dl
      if (i == 0) begin : g_first
         always_ff @(posedge clock) begin
            if (reset) begin
               dl_ff[0].valid <= 1'b0;
            end else begin
               dl_ff[0].valid <= s0_valid_ff;
            end
            dl_ff[0].kind  <= s0_ff.kind;
            dl_ff[0].err   <= s0_ff.err;
            dl_ff[0].col   <= s0_ff.col;
            dl_ff[0].row   <= s0_ff.row;
            dl_ff[0].pixel <= s0_ff.pixel;
         end
      end else begin : g_next
         always_ff @(posedge clock) begin
            if (reset) begin
               dl_ff[i].valid <= 1'b0;
            end else begin
               dl_ff[i].valid <= dl_ff[i-1].valid;
            end
            dl_ff[i].kind  <= dl_ff[i-1].kind;
            dl_ff[i].err   <= dl_ff[i-1].err;
            dl_ff[i].col   <= dl_ff[i-1].col;
            dl_ff[i].row   <= dl_ff[i-1].row;
            dl_ff[i].pixel <= dl_ff[i-1].pixel;
         end
      end
   end

   // neighbours, weights and bank addresses
   meta_type      md;
   addr_type      a_ff, a_in;
   logic [CW-1:0] x1, x0, y1, y0;
   logic          x0v, x1v, y0v, y1v;
   logic [17:0]   lw_full, tw_full;
   logic [WW-1:0] lw, rw, tw, bw, h0, h1, v0, v1;
   logic [CW-1:0] xs, ys;

   assign md = dl_ff[QW-1];

   always_comb begin
      x1      = CW'((18'(ux) + 18'd128) >> 8);
      y1      = CW'((18'(uy) + 18'd128) >> 8);
      x0      = x1 - 1'b1;
      y0      = y1 - 1'b1;
      x0v     = x1 != '0;
      y0v     = y1 != '0;
      x1v     = x1 < sizes.src_w;
      y1v     = y1 < sizes.src_h;
      lw_full = 18'({x1, 8'd0}) + 18'd128 - 18'(ux);
      tw_full = 18'({y1, 8'd0}) + 18'd128 - 18'(uy);
      lw      = lw_full[WW-1:0];
      tw      = tw_full[WW-1:0];
      rw      = WW'(256) - lw;
      bw      = WW'(256) - tw;
      h0      = (x0v && x1v) ? lw : (x0v ? WW'(256) : '0);
      h1      = (x0v && x1v) ? rw : (x0v ? '0 : WW'(256));
      v0      = (y0v && y1v) ? tw : (y0v ? WW'(256) : '0);
      v1      = (y0v && y1v) ? bw : (y0v ? '0 : WW'(256));

      a_in.valid   = md.valid;
      a_in.kind    = md.kind;
      a_in.err     = md.err;
      a_in.pixel   = md.pixel;
      a_in.wr_en   = (md.kind == bis_pkg::KIND_LOAD) &&
                     (32'(md.col) < MAX_WIDTH) && (32'(md.row) < MAX_HEIGHT);
      a_in.wr_bank = {md.row[0], md.col[0]};
      a_in.wr_addr = AW'(32'(md.row[7:1]) * HALF_W + 32'(md.col[7:1]));
      xs           = '0;
      ys           = '0;
      for (int b = 0; b < 4; b++) begin
         xs        = (x0[0] == b[0]) ? x0 : x1;
         ys        = (y0[0] == b[1]) ? y0 : y1;
         a_in.h[b] = (x0[0] == b[0]) ? h0 : h1;
         a_in.v[b] = (y0[0] == b[1]) ? v0 : v1;
         a_in.addr[b] = AW'(32'(ys[CW-1:1]) * HALF_W + 32'(xs[CW-1:1]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff.valid <= 1'b0;
      end else begin
         a_ff.valid <= a_in.valid;
      end
      a_ff.kind    <= a_in.kind;
      a_ff.err     <= a_in.err;
      a_ff.pixel   <= a_in.pixel;
      a_ff.wr_en   <= a_in.wr_en;
      a_ff.wr_bank <= a_in.wr_bank;
      a_ff.wr_addr <= a_in.wr_addr;
      a_ff.addr    <= a_in.addr;
      a_ff.h       <= a_in.h;
      a_ff.v       <= a_in.v;
   end

   // banked store read and weight products
   logic [bis_pkg::PIX_W-1:0] rd_ff   [4];
   logic [PW-1:0]             w_ff    [4];
   logic [PW-1:0]             w_in    [4];
   logic                      used_ff [4];
   tag_type                   m_ff;

   for (genvar b = 0; b < 4; b++) begin : g_bank
      logic [bis_pkg::PIX_W-1:0] store_ff [BANK_DEPTH];

      always_ff @(posedge clock) begin
         if (a_ff.valid && a_ff.wr_en && (a_ff.wr_bank == 2'(b))) begin
            store_ff[a_ff.wr_addr] <= a_ff.pixel;
         end
         rd_ff[b] <= store_ff[a_ff.addr[b]];
      end

      always_comb begin
         w_in[b] = PW'(a_ff.h[b] * a_ff.v[b]);
      end

      always_ff @(posedge clock) begin
         w_ff[b]    <= w_in[b];
         used_ff[b] <= w_in[b] != '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_ff.valid <= 1'b0;
      end else begin
         m_ff.valid <= a_ff.valid;
      end
      m_ff.kind <= a_ff.kind;
      m_ff.err  <= a_ff.err;
   end

   // per channel products
   logic [XW-1:0] prod_ff [4][4];
   tag_type       p_ff;

   for (genvar b = 0; b < 4; b++) begin : g_prod
      for (genvar c = 0; c < 4; c++) begin : g_ch
         logic [7:0] chan;
         assign chan = rd_ff[b][8*c +: 8] & {8{used_ff[b]}};
         always_ff @(posedge clock) begin
            prod_ff[b][c] <= XW'(chan * w_ff[b]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_ff.valid <= 1'b0;
      end else begin
         p_ff.valid <= m_ff.valid;
      end
      p_ff.kind <= m_ff.kind;
      p_ff.err  <= m_ff.err;
   end

   // sum, round half up, saturate
   logic [XW+1:0]             sum;
   logic [bis_pkg::PIX_W-1:0] color;

   always_comb begin
      color = '0;
      sum   = '0;
      for (int c = 0; c < 4; c++) begin
         sum = (XW+2)'(32768) + (XW+2)'(prod_ff[0][c]) + (XW+2)'(prod_ff[1][c]) +
               (XW+2)'(prod_ff[2][c]) + (XW+2)'(prod_ff[3][c]);
         color[8*c +: 8] = (sum[XW+1:16] > (XW-14)'(255)) ? 8'hFF : sum[23:16];
      end
      res_push       = p_ff.valid && (p_ff.kind == bis_pkg::KIND_REQ);
      res_data.err   = p_ff.err;
      res_data.pixel = p_ff.err ? '0 : color;
   end

endmodule

// File: hw/rtl/bilinear_image_scaler.sv
// bilinear ARGB image scaler: one load or request word per cycle sustained while the
// result buffer can take more; the source position dividers have 17 stages each
// results are buffered 32 deep, issue holds back only when that buffer is committed
// synchronous active-high reset clears control and sets all sizes to 1;
// the source store is not cleared and holds nothing defined until loaded
module bilinear_image_scaler #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // col[7:0], row[15:8], pixel_in[47:16]
   input  logic [0:0]  req_tuser,   // kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // pixel_out[31:0]
   output logic [0:0]  rsp_tuser,   // coord_error
   input  logic        csr_wen,
   input  logic [1:0]  csr_index,
   input  logic [8:0]  csr_wdata
);

   logic [8:0] src_w_ff, src_h_ff, dst_w_ff, dst_h_ff;
   bis_pkg::size_type   sizes;
   bis_pkg::item_type   f_item, q_item;
   logic                q_push, q_pop, q_full, q_empty;
   logic [$bits(bis_pkg::item_type)-1:0] q_dout;
   logic                res_push, rsp_empty, rsp_full, rsp_done;
   bis_pkg::result_type res_data;
   logic [$bits(bis_pkg::result_type)-1:0] res_dout;
   bis_pkg::result_type res_head;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_w_ff <= 9'd1;
         src_h_ff <= 9'd1;
         dst_w_ff <= 9'd1;
         dst_h_ff <= 9'd1;
      end else if (csr_wen) begin
         unique case (bis_pkg::reg_index_type'(csr_index))
            bis_pkg::REG_SRC_W: src_w_ff <= csr_wdata;
            bis_pkg::REG_SRC_H: src_h_ff <= csr_wdata;
            bis_pkg::REG_DST_W: dst_w_ff <= csr_wdata;
            bis_pkg::REG_DST_H: dst_h_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      sizes.src_w = bis_pkg::clamp_size(src_w_ff, MAX_WIDTH);
      sizes.src_h = bis_pkg::clamp_size(src_h_ff, MAX_HEIGHT);
      sizes.dst_w = bis_pkg::clamp_size(dst_w_ff, MAX_WIDTH);
      sizes.dst_h = bis_pkg::clamp_size(dst_h_ff, MAX_HEIGHT);
   end

   bis_front u_front (
      .clock      (clock),
      .reset      (reset),
      .sizes      (sizes),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_item     (f_item)
   );

   bis_fifo #(
      .WIDTH ($bits(bis_pkg::item_type)),
      .DEPTH (bis_pkg::Q_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .din   (f_item),
      .pop   (q_pop),
      .dout  (q_dout),
      .full  (q_full),
      .empty (q_empty)
   );

   assign q_item = bis_pkg::item_type'(q_dout);

   bis_back #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .sizes    (sizes),
      .q_empty  (q_empty),
      .q_item   (q_item),
      .q_pop    (q_pop),
      .rsp_done (rsp_done),
      .res_push (res_push),
      .res_data (res_data)
   );

   bis_fifo #(
      .WIDTH ($bits(bis_pkg::result_type)),
      .DEPTH (bis_pkg::OUT_DEPTH)
   ) u_rsp_buf (
      .clock (clock),
      .reset (reset),
      .push  (res_push),
      .din   (res_data),
      .pop   (rsp_done),
      .dout  (res_dout),
      .full  (rsp_full),
      .empty (rsp_empty)
   );

   assign res_head   = bis_pkg::result_type'(res_dout);
   assign rsp_tvalid = !rsp_empty;
   assign rsp_done   = rsp_tvalid && rsp_tready && !(rsp_full && 1'b0);
   assign rsp_tdata  = res_head.pixel;
   assign rsp_tuser  = res_head.err;

endmodule

// File: hw/rtl/bis_checker.sv
// port-level checks for the bilinear image scaler, bound to the top level
// depends on bilinear_image_scaler_defines.svh
`include "bilinear_image_scaler_defines.svh"

module bis_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic [0:0]  rsp_tuser
);

   `BIS_ASSERT_SAME(a_err_zero, clock, reset, rsp_tvalid && rsp_tuser[0], rsp_tdata == 32'd0)
   `BIS_ASSERT_ALWAYS(a_reset_empty, clock, reset, !rsp_tvalid)
   `BIS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `BIS_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata))

endmodule

bind bilinear_image_scaler bis_checker u_bis_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// File: bench/bis_checker.sv
`timescale 1ns / 1ps
// checker for the bilinear image scaler: watches the request, result and register ports,
// predicts each result from its own copy of the sizes and the source store, compares in order
// depends on bis_pkg
module bis_scoreboard (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [47:0] req_tdata,   // col[7:0], row[15:8], pixel_in[47:16]
   input  logic [0:0]  req_tuser,   // kind
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,   // pixel_out[31:0]
   input  logic [0:0]  rsp_tuser,   // coord_error
   input  logic        csr_wen,
   input  logic [1:0]  csr_index,
   input  logic [8:0]  csr_wdata,
   output int          fail_count,
   output int          waiting,
   output int          results_seen,
   output int          four_tap_seen,
   output int          coord_errors_seen
);

   logic [31:0]         src_pixels [0:65535];
   logic [8:0]          src_w, src_h, dst_w, dst_h;
   bis_pkg::result_type scaled_q[$];
   logic                last_four_tap;

   initial begin
      fail_count = 0;
      waiting = 0;
      results_seen = 0;
      four_tap_seen = 0;
      coord_errors_seen = 0;
   end

   function automatic int unsigned fit_size(input logic [8:0] v);
      if (v == 9'd0) return 1;
      if (v > 9'd256) return 256;
      return int'(v);
   endfunction

   // per-channel weighted sum, Q16 weights, round half up
   function automatic logic [31:0] weigh(input logic [31:0] p0, p1, p2, p3,
                                         input int unsigned w0, w1, w2, w3);
      logic [31:0]     res;
      longint unsigned acc;
      res = '0;
      for (int sh = 0; sh < 32; sh += 8) begin
         acc = 32768;
         acc += longint'((p0 >> sh) & 32'hFF) * w0;
         acc += longint'((p1 >> sh) & 32'hFF) * w1;
         acc += longint'((p2 >> sh) & 32'hFF) * w2;
         acc += longint'((p3 >> sh) & 32'hFF) * w3;
         acc = acc >> 16;
         if (acc > 255) acc = 255;
         res |= 32'(acc) << sh;
      end
      return res;
   endfunction

   function automatic bis_pkg::result_type scale_pixel(input logic [7:0] col,
                                                       input logic [7:0] row);
      int unsigned sw, sh, dw, dh, ux, uy, x0, x1, y0, y1, lw, rw, tw, bw, xx, yy;
      bit                  x0v, x1v, y0v, y1v;
      bis_pkg::result_type r;
      sw = fit_size(src_w);
      sh = fit_size(src_h);
      dw = fit_size(dst_w);
      dh = fit_size(dst_h);
      r.err = 1'b0;
      r.pixel = '0;
      last_four_tap = 1'b0;
      if (col >= dw || row >= dh) begin
         r.err = 1'b1;
         return r;
      end
      ux = ((2 * int'(col) + 1) * sw * 128) / dw;
      uy = ((2 * int'(row) + 1) * sh * 128) / dh;
      x1 = (ux + 128) >> 8;
      y1 = (uy + 128) >> 8;
      x0 = x1 - 1;
      y0 = y1 - 1;
      x0v = x1 >= 1;
      y0v = y1 >= 1;
      x1v = x1 < sw;
      y1v = y1 < sh;
      lw = x1 * 256 + 128 - ux;
      rw = 256 - lw;
      tw = y1 * 256 + 128 - uy;
      bw = 256 - tw;
      xx = x0v ? x0 : x1;
      yy = y0v ? y0 : y1;
      if (x0v && x1v && y0v && y1v) begin
         last_four_tap = 1'b1;
         r.pixel = weigh(src_pixels[y0*256+x0], src_pixels[y0*256+x1],
                         src_pixels[y1*256+x0], src_pixels[y1*256+x1],
                         lw * tw, rw * tw, lw * bw, rw * bw);
      end else if (x0v && x1v) begin
         r.pixel = weigh(src_pixels[yy*256+x0], src_pixels[yy*256+x1], '0, '0,
                         lw * 256, rw * 256, 0, 0);
      end else if (y0v && y1v) begin
         r.pixel = weigh(src_pixels[y0*256+xx], src_pixels[y1*256+xx], '0, '0,
                         tw * 256, bw * 256, 0, 0);
      end else begin
         r.pixel = src_pixels[yy*256+xx];
      end
      return r;
   endfunction

   always @(posedge clock) begin
      bis_pkg::result_type want;
      if (reset) begin
         src_w = 9'd1;
         src_h = 9'd1;
         dst_w = 9'd1;
         dst_h = 9'd1;
         scaled_q.delete();
      end else begin
         if (csr_wen) begin
            case (bis_pkg::reg_index_type'(csr_index))
               bis_pkg::REG_SRC_W: src_w = csr_wdata;
               bis_pkg::REG_SRC_H: src_h = csr_wdata;
               bis_pkg::REG_DST_W: dst_w = csr_wdata;
               bis_pkg::REG_DST_H: dst_h = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (scaled_q.size() == 0) begin
               fail_count++;
               $display("%0t unexpected word: pixel %h err %b", $time, rsp_tdata, rsp_tuser);
            end else begin
               want = scaled_q.pop_front();
               if (want.err != rsp_tuser[0]) begin
                  fail_count++;
                  $display("%0t coord_error: expected %b actual %b", $time, want.err,
                           rsp_tuser[0]);
               end
               if (want.pixel != rsp_tdata) begin
                  fail_count++;
                  $display("%0t pixel_out: expected %h actual %h", $time, want.pixel,
                           rsp_tdata);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            if (bis_pkg::kind_type'(req_tuser[0]) == bis_pkg::KIND_LOAD) begin
               src_pixels[{req_tdata[15:8], req_tdata[7:0]}] = req_tdata[47:16];
            end else begin
               want = scale_pixel(req_tdata[7:0], req_tdata[15:8]);
               if (want.err) coord_errors_seen++;
               if (last_four_tap) four_tap_seen++;
               scaled_q.push_back(want);
            end
         end
      end
      waiting = scaled_q.size();
   end

endmodule

// File: bench/tb_bilinear_image_scaler.sv
`timescale 1ns / 1ps
// top of the bilinear image scaler bench: clock, reset, register phases, load and request
// stimulus with random idling and a long result stall; verdict from bis_scoreboard
// depends on bis_pkg, bis_scoreboard and bilinear_image_scaler
module tb_bilinear_image_scaler;

   localparam int CYCLE_LIMIT = 1500000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;   // col[7:0], row[15:8], pixel_in[47:16]
   logic [0:0]  req_tuser = '0;   // kind
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // pixel_out[31:0]
   logic [0:0]  rsp_tuser;        // coord_error
   logic        csr_wen = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [8:0]  csr_wdata = '0;

   int fail_count, waiting, results_seen, four_tap_seen, coord_errors_seen;
   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   int hold_left = 0;
   bit hold_asked = 0;
   int words_sent = 0;
   int cycles = 0;
   int unsigned sw, sh, dw, dh;

   bilinear_image_scaler dut (.*);

   bis_scoreboard checker_i (.*);

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("status: fail");
         $finish;
      end
   end

   // result side backpressure with one long hold-off
   always @(negedge clock) begin
      if (hold_asked) begin
         hold_asked = 0;
         hold_left = 400;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   task automatic send_word(input bis_pkg::kind_type kind, input logic [7:0] col,
                            input logic [7:0] row, input logic [31:0] pix);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {pix, row, col};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      words_sent++;
   endtask

   task automatic drain;
      req_tvalid <= 1'b0;
      while (waiting != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic set_sizes(input logic [8:0] a, b, c, d);
      csr_wen <= 1'b1;
      csr_index <= bis_pkg::REG_SRC_W;
      csr_wdata <= a;
      @(negedge clock);
      csr_index <= bis_pkg::REG_SRC_H;
      csr_wdata <= b;
      @(negedge clock);
      csr_index <= bis_pkg::REG_DST_W;
      csr_wdata <= c;
      @(negedge clock);
      csr_index <= bis_pkg::REG_DST_H;
      csr_wdata <= d;
      @(negedge clock);
      csr_wen <= 1'b0;
      sw = (a == 0) ? 1 : (a > 256) ? 256 : a;
      sh = (b == 0) ? 1 : (b > 256) ? 256 : b;
      dw = (c == 0) ? 1 : (c > 256) ? 256 : c;
      dh = (d == 0) ? 1 : (d > 256) ? 256 : d;
   endtask

   task automatic fill_source(input bit extremes);
      logic [31:0] pix;
      for (int r = 0; r < sh; r++) begin
         for (int c = 0; c < sw; c++) begin
            pix = $urandom;
            if (extremes) pix = ((r + c) % 2) ? 32'hFFFF_FFFF : 32'h0;
            send_word(bis_pkg::KIND_LOAD, 8'(c), 8'(r), pix);
         end
      end
   endtask

   task automatic random_traffic(input int count);
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(9))
            0: send_word(bis_pkg::KIND_LOAD, 8'($urandom_range(sw - 1)),
                         8'($urandom_range(sh - 1)), $urandom);
            1: send_word(bis_pkg::KIND_REQ, 8'($urandom), 8'($urandom), $urandom);
            default: send_word(bis_pkg::KIND_REQ, 8'($urandom_range(dw - 1)),
                               8'($urandom_range(dh - 1)), $urandom);
         endcase
      end
   endtask

   initial begin
      int phase;
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // small grid with extreme pixels, corners and out of range requests
      set_sizes(9'd2, 9'd2, 9'd3, 9'd3);
      fill_source(1);
      send_word(bis_pkg::KIND_LOAD, 8'd255, 8'd255, 32'h8000_0001);
      send_word(bis_pkg::KIND_REQ, 8'd0, 8'd0, 32'hFFFF_FFFF);
      send_word(bis_pkg::KIND_REQ, 8'd1, 8'd1, '0);
      send_word(bis_pkg::KIND_REQ, 8'd2, 8'd2, '0);
      send_word(bis_pkg::KIND_REQ, 8'd1, 8'd0, '0);
      send_word(bis_pkg::KIND_REQ, 8'd0, 8'd2, '0);
      send_word(bis_pkg::KIND_REQ, 8'd3, 8'd0, '0);
      send_word(bis_pkg::KIND_REQ, 8'd0, 8'd3, '0);
      send_word(bis_pkg::KIND_REQ, 8'd255, 8'd255, '0);
      drain();

      phase = 0;
      while (words_sent < 1750) begin
         tx_idle_pct = (phase % 4 == 1) ? 55 : (phase % 4 == 3) ? 28 : 0;
         rx_idle_pct = (phase % 4 == 2) ? 55 : (phase % 4 == 3) ? 28 : 0;
         case (phase)
            0: set_sizes(9'd1, 9'd1, 9'd1, 9'd1);
            1: set_sizes(9'd256, 9'd1, 9'd7, 9'd1);
            2: set_sizes(9'd1, 9'd256, 9'd1, 9'd200);
            3: set_sizes(9'd5, 9'd4, 9'd256, 9'd256);
            4: set_sizes(9'd16, 9'd12, 9'd5, 9'd3);
            5: set_sizes(9'd0, 9'd511, 9'd300, 9'd0);
            6: set_sizes(9'd9, 9'd7, 9'd13, 9'd11);
            default: set_sizes(9'($urandom_range(1, 12)), 9'($urandom_range(1, 12)),
                               9'($urandom_range(1, 40)), 9'($urandom_range(1, 40)));
         endcase
         fill_source(0);
         if (phase == 3) hold_asked = 1;
         random_traffic(phase == 3 ? 150 : 60);
         drain();
         phase++;
      end

      $display("sent %0d words over %0d size settings, %0d results checked",
               words_sent, phase + 1, results_seen);
      $display("%0d four-tap blends, %0d out of range requests", four_tap_seen,
               coord_errors_seen);
      if (fail_count == 0 && waiting == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
